// ===== rtl/cswa_pkg.sv =====
// Shared types, register codes and the cosine table builder for the cosine window block.
// Depends on nothing; the cosine table, weight datapath and top level import it.
`timescale 1ns / 1ps
package cswa_pkg;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_LENGTH = 3'd0;
    localparam logic [2:0] REG_STEP   = 3'd1;
    localparam logic [2:0] REG_COEF0  = 3'd2;
    localparam logic [2:0] REG_COEF1  = 3'd3;
    localparam logic [2:0] REG_COEF2  = 3'd4;
    localparam logic [2:0] REG_COEF3  = 3'd5;
    localparam logic [2:0] REG_COEF4  = 3'd6;

    localparam int CFG_DATA_BITS = 32;
    localparam int COEF_BITS     = 17;
    localparam int WEIGHT_BITS   = 18;
    localparam int TERM_BITS     = 37;
    localparam int ACC_BITS      = 40;
    localparam int HARMONICS     = 4;

    // Reset values of the registers
    localparam logic [12:0] LENGTH_RST = 13'd1024;
    localparam logic [31:0] STEP_RST   = 32'd4198405;
    localparam logic [16:0] COEF0_RST  = 17'd32768;
    localparam logic [16:0] COEF1_RST  = 17'd32768;
    localparam logic [16:0] COEF_RST   = 17'd0;

    // Enables of the two weight stages
    typedef struct packed {
        logic en_mul;
        logic en_sum;
    } wsum_ctl_t;

    // Taylor-series cosine of pi/2*i/2^b in Q1.16, evaluated at elaboration
    function automatic logic [16:0] cos_entry(input int i, input int b);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint sum;
        longint r;
        x    = (64'd1686629713 * longint'(i)) >> b;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = longint'(term);
        // Twelve series terms, each divided by (2k-1)(2k)
        term = ((term * x2) >> 30) / 64'd2;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd12;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd30;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd56;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd90;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd132;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd182;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd240;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd306;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd380;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd462;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd552;
        sum  = sum + longint'(term);
        if (sum < 0)
            sum = 0;
        r = (sum + 64'sd8192) >>> 14;
        if (r > 65536)
            r = 65536;
        if (i == (1 << b))
            r = 0;
        return r[16:0];
    endfunction

endpackage

// ===== rtl/cswa_in_if.sv =====
// Input channel: valid/ready handshake with sample and frame index.
// Depends on nothing.
`timescale 1ns / 1ps
interface cswa_in_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [11:0]                   sample_index;

    modport source (output valid, sample, sample_index, input ready);
    modport sink (input valid, sample, sample_index, output ready);
endinterface

// ===== rtl/cswa_out_if.sv =====
// Output channel: valid/ready handshake with windowed sample, weight and flags.
// Depends on nothing.
`timescale 1ns / 1ps
interface cswa_out_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] windowed_sample;
    logic signed [17:0]            weight;
    logic                          frame_last;
    logic                          index_over;

    modport source (output valid, windowed_sample, weight, frame_last, index_over,
                    input ready);
    modport sink (input valid, windowed_sample, weight, frame_last, index_over,
                  output ready);
endinterface

// ===== rtl/cswa_cos_lut.sv =====
// Quarter-wave cosine lookup: quadrant fold of a circle address into a constant table.
// Depends on cswa_pkg for the table builder.
`timescale 1ns / 1ps
module cswa_cos_lut
    import cswa_pkg::*;
#(
    parameter int COS_TABLE_BITS = 10
)
(
    input  logic [COS_TABLE_BITS+1:0] addr,
    output logic signed [17:0]        cos_val
);
    localparam int TSIZE = (1 << COS_TABLE_BITS) + 1;

    logic [16:0]             rom [TSIZE];
    logic [1:0]              quad;
    logic [COS_TABLE_BITS:0] off;
    logic [COS_TABLE_BITS:0] mirror;
    logic [16:0]             mag;

    // Build the constant table
    for (genvar gi = 0; gi < TSIZE; gi++)
    begin : g_rom
        assign rom[gi] = cos_entry(gi, COS_TABLE_BITS);
    end

    // Fold the quadrant and restore the sign
    always_comb
    begin
        quad   = addr[COS_TABLE_BITS+1:COS_TABLE_BITS];
        off    = {1'b0, addr[COS_TABLE_BITS-1:0]};
        mirror = (COS_TABLE_BITS+1)'(1 << COS_TABLE_BITS) - off;
        case (quad)
            2'd0:    mag = rom[off];
            2'd1:    mag = rom[mirror];
            2'd2:    mag = rom[off];
            default: mag = rom[mirror];
        endcase
        if (quad == 2'd1 || quad == 2'd2)
            cos_val = -$signed({1'b0, mag});
        else
            cos_val = $signed({1'b0, mag});
    end
endmodule

// ===== rtl/cswa_weight_sum.sv =====
// Weight datapath: four coefficient products, then signed sum, rounding and saturation.
// Depends on cswa_pkg for widths and the stage enable struct.
`timescale 1ns / 1ps
module cswa_weight_sum
    import cswa_pkg::*;
(
    input  logic                          clk,
    input  wsum_ctl_t                     ctl,
    input  logic [COEF_BITS-1:0]          coef [HARMONICS+1],
    input  logic signed [17:0]            cos_val [HARMONICS],
    output logic signed [WEIGHT_BITS-1:0] weight
);
    logic signed [TERM_BITS-1:0]   term_reg [HARMONICS];
    logic signed [ACC_BITS-1:0]    acc;
    logic signed [ACC_BITS-1:0]    rnd;
    logic signed [WEIGHT_BITS-1:0] weight_next;
    logic signed [WEIGHT_BITS-1:0] weight_reg;

    // Multiply each harmonic by its coefficient
    always_ff @(posedge clk)
    begin
        if (ctl.en_mul)
        begin
            for (int k = 0; k < HARMONICS; k++)
                term_reg[k] <= TERM_BITS'($signed({1'b0, coef[k+1]}) * cos_val[k]);
        end
    end

    // Sum with alternating signs, round half up, saturate
    always_comb
    begin
        acc = ACC_BITS'($signed({1'b0, coef[0], 16'b0}))
            - ACC_BITS'(term_reg[0]) + ACC_BITS'(term_reg[1])
            - ACC_BITS'(term_reg[2]) + ACC_BITS'(term_reg[3]);
        rnd = (acc + ACC_BITS'(32768)) >>> 16;
        if (rnd > ACC_BITS'(65536))
            weight_next = WEIGHT_BITS'(65536);
        else if (rnd < -ACC_BITS'(65536))
            weight_next = -WEIGHT_BITS'(65536);
        else
            weight_next = rnd[WEIGHT_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_sum)
            weight_reg <= weight_next;
    end

    assign weight = weight_reg;
endmodule

// ===== rtl/cosine_sum_window_apply.sv =====
// Top level of the five-term cosine window: config registers, pipeline control and stages.
// Depends on cswa_pkg, cswa_in_if, cswa_out_if, cswa_cos_lut and cswa_weight_sum.
// Throughput one item per cycle while the output is not stalled.
// Each stage holds when the stage after it is full and stalled, so bubbles close up.
// Reset clears all valid bits and loads the Hann setup for a 1024-sample frame.
`timescale 1ns / 1ps
module cosine_sum_window_apply
    import cswa_pkg::*;
#(
    parameter int MAX_LENGTH     = 4096,
    parameter int COS_TABLE_BITS = 10,
    parameter int SAMPLE_BITS    = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    cswa_in_if.sink                  din,
    cswa_out_if.source               dout,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);
    localparam int STAGES = 7;
    localparam int AB     = COS_TABLE_BITS + 2;
    localparam int SHIFT  = 30 - COS_TABLE_BITS;
    localparam int PB     = SAMPLE_BITS + WEIGHT_BITS;
    localparam logic [16:0] MAX_LEN = 17'(MAX_LENGTH);

    typedef logic signed [SAMPLE_BITS-1:0] smp_t;

    // Configuration registers
    logic [12:0]          length_reg;
    logic [31:0]          step_reg;
    logic [COEF_BITS-1:0] coef_reg [HARMONICS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg  <= LENGTH_RST;
            step_reg    <= STEP_RST;
            coef_reg[0] <= COEF0_RST;
            coef_reg[1] <= COEF1_RST;
            coef_reg[2] <= COEF_RST;
            coef_reg[3] <= COEF_RST;
            coef_reg[4] <= COEF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LENGTH: length_reg  <= cfg_wdata[12:0];
                REG_STEP:   step_reg    <= cfg_wdata;
                REG_COEF0:  coef_reg[0] <= cfg_wdata[COEF_BITS-1:0];
                REG_COEF1:  coef_reg[1] <= cfg_wdata[COEF_BITS-1:0];
                REG_COEF2:  coef_reg[2] <= cfg_wdata[COEF_BITS-1:0];
                REG_COEF3:  coef_reg[3] <= cfg_wdata[COEF_BITS-1:0];
                REG_COEF4:  coef_reg[4] <= cfg_wdata[COEF_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Stage valid bits and per-stage advance enables
    logic [STAGES:1]   vld_reg;
    logic [STAGES+1:1] en;

    always_comb
    begin
        en[STAGES+1] = dout.ready;
        for (int k = STAGES; k >= 1; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[1])
                vld_reg[1] <= din.valid;
            for (int k = 2; k <= STAGES; k++)
            begin
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    assign din.ready = en[1];

    // Sideband carried alongside the data
    smp_t        smp_reg  [1:5];
    logic [1:6]  over_reg;
    logic [1:6]  last_reg;

    // Stage 1: length checks and base phase
    logic [16:0] len_eff;
    logic [31:0] phase1_reg;

    assign len_eff = ({4'b0, length_reg} > MAX_LEN) ? MAX_LEN : {4'b0, length_reg};

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            smp_reg[1]  <= din.sample;
            over_reg[1] <= {5'b0, din.sample_index} >= len_eff;
            last_reg[1] <= (len_eff != 17'd0) && ({5'b0, din.sample_index} == len_eff - 17'd1);
            phase1_reg  <= 32'({32'b0, din.sample_index} * {32'b0, step_reg});
        end
    end

    // Stage 2: harmonic phases rounded to circle addresses
    logic [31:0]   hphase [HARMONICS];
    logic [AB-1:0] addr2_reg [HARMONICS];

    always_comb
    begin
        hphase[0] = phase1_reg;
        hphase[1] = {phase1_reg[30:0], 1'b0};
        hphase[2] = phase1_reg + {phase1_reg[30:0], 1'b0};
        hphase[3] = {phase1_reg[29:0], 2'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            smp_reg[2]  <= smp_reg[1];
            over_reg[2] <= over_reg[1];
            last_reg[2] <= last_reg[1];
            for (int k = 0; k < HARMONICS; k++)
                addr2_reg[k] <= AB'((hphase[k] + (32'd1 << (SHIFT - 1))) >> SHIFT);
        end
    end

    // Stage 3: table lookups
    logic signed [17:0] cos_comb [HARMONICS];
    logic signed [17:0] cos3_reg [HARMONICS];

    for (genvar gh = 0; gh < HARMONICS; gh++)
    begin : g_cos
        cswa_cos_lut #(.COS_TABLE_BITS(COS_TABLE_BITS)) u_lut
        (
            .addr    (addr2_reg[gh]),
            .cos_val (cos_comb[gh])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            smp_reg[3]  <= smp_reg[2];
            over_reg[3] <= over_reg[2];
            last_reg[3] <= last_reg[2];
            cos3_reg    <= cos_comb;
        end
    end

    // Stages 4 and 5: coefficient products and weight sum
    wsum_ctl_t                     wctl;
    logic signed [WEIGHT_BITS-1:0] weight5;

    assign wctl.en_mul = en[4];
    assign wctl.en_sum = en[5];

    cswa_weight_sum u_wsum
    (
        .clk     (clk),
        .ctl     (wctl),
        .coef    (coef_reg),
        .cos_val (cos3_reg),
        .weight  (weight5)
    );

    always_ff @(posedge clk)
    begin
        for (int k = 4; k <= 5; k++)
        begin
            if (en[k])
            begin
                smp_reg[k]  <= smp_reg[k-1];
                over_reg[k] <= over_reg[k-1];
                last_reg[k] <= last_reg[k-1];
            end
        end
    end

    // Stage 6: zero the weight past the frame, scale the sample
    logic signed [WEIGHT_BITS-1:0] weight6;
    logic signed [WEIGHT_BITS-1:0] weight6_reg;
    logic signed [PB-1:0]          prod6_reg;

    assign weight6 = over_reg[5] ? '0 : weight5;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            over_reg[6] <= over_reg[5];
            last_reg[6] <= last_reg[5];
            weight6_reg <= weight6;
            prod6_reg   <= PB'(smp_reg[5] * weight6);
        end
    end

    // Stage 7: round, saturate and hold the result
    logic signed [PB-1:0]    rnd7;
    smp_t                    ws_next;
    smp_t                    ws_reg;
    logic signed [17:0]      weight7_reg;
    logic                    last7_reg;
    logic                    over7_reg;
    localparam logic signed [PB-1:0] SMAX = PB'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

    always_comb
    begin
        rnd7 = (prod6_reg + PB'(32768)) >>> 16;
        if (rnd7 > SMAX)
            ws_next = SMAX[SAMPLE_BITS-1:0];
        else if (rnd7 < -SMAX - PB'(1))
            ws_next = SAMPLE_BITS'(-SMAX - PB'(1));
        else
            ws_next = rnd7[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            ws_reg      <= ws_next;
            weight7_reg <= weight6_reg;
            last7_reg   <= last_reg[6];
            over7_reg   <= over_reg[6];
        end
    end

    assign dout.valid           = vld_reg[STAGES];
    assign dout.windowed_sample = ws_reg;
    assign dout.weight          = weight7_reg;
    assign dout.frame_last      = last7_reg;
    assign dout.index_over      = over7_reg;

`ifndef SYNTHESIS
    // Past-the-frame results carry zero weight and zero sample
    a_over_zero: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && dout.index_over |-> dout.weight == '0 && dout.windowed_sample == '0)
        else $error("index_over result with nonzero weight");

    // A last-of-frame index is never past the frame
    a_last_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid |-> !(dout.frame_last && dout.index_over))
        else $error("frame_last and index_over both set");

    // An empty output stage never blocks the input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !dout.valid |-> din.ready)
        else $error("input stalled while output stage empty");

    // A stalled result holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && !dout.ready |=> $stable(dout.weight) && $stable(dout.windowed_sample))
        else $error("stalled result changed");
`endif
endmodule
